@@ rtl/oul_pkg.sv @@
// Shared types, codes and defaults for the ordered unique id list.
package oul_pkg;

   localparam int DEFAULT_LIST_DEPTH = 64;
   localparam int DEFAULT_ID_WIDTH   = 32;

   localparam int MODE_WIDTH   = 2;
   localparam int ID_FIELD_W   = 32;
   localparam int POS_WIDTH    = 7;
   localparam int STATUS_WIDTH = 3;
   localparam int COUNT_FIELD_W = 7;

   localparam logic [MODE_WIDTH-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_MOVE   = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_RSVD   = 2'd3;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_DUP      = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL     = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NOTFOUND = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] STATUS_INVALID  = 3'd4;

   typedef struct packed {
      logic [MODE_WIDTH-1:0] mode;
      logic [ID_FIELD_W-1:0] item_id;
      logic [POS_WIDTH-1:0]  target_position;
   } req_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]  status;
      logic [COUNT_FIELD_W-1:0] entry_count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                    start;
      logic                    scan_step;
      logic                    shift_init;
      logic                    shift_step;
      logic                    append_wr;
      logic                    place_wr;
      logic                    dec_count;
      logic                    set_status;
      logic [STATUS_WIDTH-1:0] status_code;
      logic                    load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic invalid;
      logic hit;
      logic miss;
      logic full;
      logic shift_done;
      logic is_append;
      logic is_remove;
   } stat_type;

endpackage

@@ rtl/oul_dp.sv @@
// Datapath of the ordered unique id list: entry memory, count, scan and shift pointers.
module oul_dp #(
   parameter int LIST_DEPTH = oul_pkg::DEFAULT_LIST_DEPTH,
   parameter int ID_WIDTH   = oul_pkg::DEFAULT_ID_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  oul_pkg::req_type req_data,
   input  oul_pkg::cmd_type cmd,
   output oul_pkg::stat_type stat,
   output oul_pkg::rsp_type rsp_data
);
   import oul_pkg::*;

   localparam int IDX_W = $clog2(LIST_DEPTH);
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_WIDTH) ? CNT_W : POS_WIDTH;

   logic [ID_WIDTH-1:0] entry_store_ff [LIST_DEPTH];

   logic [MODE_WIDTH-1:0]   mode_ff, mode_in;
   logic [ID_WIDTH-1:0]     id_ff, id_in;
   logic [POS_WIDTH-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        scan_idx_ff, scan_idx_in;
   logic                    cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [ID_WIDTH-1:0]     rd_data_ff;
   logic [IDX_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0]        pend_dst_ff, pend_dst_in;
   logic                    pend_ff, pend_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic                    up_ff, up_in;
   logic [IDX_W-1:0]        to_ff, to_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                scan_more;
   logic [CMP_W-1:0]    pos_x, cnt_x, pos_c;
   logic [IDX_W-1:0]    to_c, diff_up, diff_dn;
   logic                up_c;
   logic [CNT_W-1:0]    n_c;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [ID_WIDTH-1:0] wr_data;

   assign scan_more = scan_idx_ff < count_ff;

   // Clamp the move position to 1..count and turn it into a slot index.
   assign pos_x = CMP_W'(pos_ff);
   assign cnt_x = CMP_W'(count_ff);
   assign pos_c = (pos_x == '0) ? CMP_W'(1) : ((pos_x > cnt_x) ? cnt_x : pos_x);
   assign to_c  = IDX_W'(pos_c - CMP_W'(1));

   assign diff_up = to_c - cmp_idx_ff;
   assign diff_dn = cmp_idx_ff - to_c;

   always_comb begin
      up_c = 1'b1;
      n_c  = count_ff - CNT_W'(cmp_idx_ff) - CNT_W'(1);
      if (mode_ff == MODE_MOVE) begin
         up_c = to_c > cmp_idx_ff;
         n_c  = up_c ? CNT_W'(diff_up) : CNT_W'(diff_dn);
      end
   end

   assign rd_addr = cmd.shift_step ? rd_ptr_ff : scan_idx_ff[IDX_W-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pend_dst_ff;
      wr_data = rd_data_ff;
      if (cmd.append_wr) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IDX_W-1:0];
         wr_data = id_ff;
      end else if (cmd.place_wr) begin
         wr_en   = 1'b1;
         wr_addr = to_ff;
         wr_data = id_ff;
      end else if (cmd.shift_step && pend_ff) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      id_in        = id_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      rd_ptr_in    = rd_ptr_ff;
      pend_dst_in  = pend_dst_ff;
      pend_in      = pend_ff;
      left_in      = left_ff;
      up_in        = up_ff;
      to_in        = to_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.start) begin
         mode_in      = req_data.mode;
         id_in        = ID_WIDTH'(req_data.item_id);
         pos_in       = req_data.target_position;
         scan_idx_in  = '0;
         cmp_valid_in = 1'b0;
      end
      if (cmd.scan_step) begin
         cmp_valid_in = scan_more;
         if (scan_more) begin
            cmp_idx_in  = scan_idx_ff[IDX_W-1:0];
            scan_idx_in = scan_idx_ff + CNT_W'(1);
         end
      end
      if (cmd.shift_init) begin
         rd_ptr_in = up_c ? cmp_idx_ff + IDX_W'(1) : cmp_idx_ff - IDX_W'(1);
         left_in   = n_c;
         up_in     = up_c;
         to_in     = to_c;
         pend_in   = 1'b0;
      end
      if (cmd.shift_step) begin
         pend_in = left_ff != '0;
         if (left_ff != '0) begin
            rd_ptr_in   = up_ff ? rd_ptr_ff + IDX_W'(1) : rd_ptr_ff - IDX_W'(1);
            pend_dst_in = up_ff ? rd_ptr_ff - IDX_W'(1) : rd_ptr_ff + IDX_W'(1);
            left_in     = left_ff - CNT_W'(1);
         end
      end
      if (cmd.append_wr) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.dec_count) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end
      if (cmd.load_rsp) begin
         rsp_data_in.status      = status_ff;
         rsp_data_in.entry_count = COUNT_FIELD_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      id_ff       <= id_in;
      pos_ff      <= pos_in;
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      rd_ptr_ff   <= rd_ptr_in;
      pend_dst_ff <= pend_dst_in;
      left_ff     <= left_in;
      up_ff       <= up_in;
      to_ff       <= to_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.invalid    = (id_ff == '0) || (mode_ff == MODE_RSVD);
   assign stat.hit        = cmp_valid_ff && (rd_data_ff == id_ff);
   assign stat.miss       = !cmp_valid_ff && !scan_more;
   assign stat.full       = count_ff == CNT_W'(LIST_DEPTH);
   assign stat.shift_done = (left_ff == '0) && !pend_ff;
   assign stat.is_append  = mode_ff == MODE_APPEND;
   assign stat.is_remove  = mode_ff == MODE_REMOVE;

   assign rsp_data = rsp_data_ff;

   count_bound_a: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LIST_DEPTH))
      else $error("entry count above list depth");

   count_step_a: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + CNT_W'(1)
                || count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("entry count changed by more than one");

endmodule

@@ rtl/oul_ctrl.sv @@
// Controller state machine of the ordered unique id list.
module oul_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  oul_pkg::stat_type stat,
   output oul_pkg::cmd_type  cmd
);
   import oul_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CHECK  = 6'b000010,
      S_SCAN   = 6'b000100,
      S_SHIFT  = 6'b001000,
      S_PLACE  = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = state_ff != S_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.invalid) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_INVALID;
               state_in        = S_FINISH;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.hit) begin
               if (stat.is_append) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = STATUS_DUP;
                  state_in        = S_FINISH;
               end else begin
                  cmd.shift_init = 1'b1;
                  state_in       = S_SHIFT;
               end
            end else if (stat.miss) begin
               cmd.set_status = 1'b1;
               state_in       = S_FINISH;
               if (!stat.is_append) begin
                  cmd.status_code = STATUS_NOTFOUND;
               end else if (stat.full) begin
                  cmd.status_code = STATUS_FULL;
               end else begin
                  cmd.status_code = STATUS_OK;
                  cmd.append_wr   = 1'b1;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (stat.shift_done) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            cmd.dec_count   = stat.is_remove;
            cmd.place_wr    = !stat.is_remove;
            cmd.set_status  = 1'b1;
            cmd.status_code = STATUS_OK;
            state_in        = S_FINISH;
         end
         S_FINISH: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   accept_starts_a: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == S_CHECK)
      else $error("accepted beat did not start an operation");

   no_overwrite_a: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while its beat is stalled");

endmodule

@@ rtl/ordered_unique_id_list.sv @@
// Top level of the ordered unique id list: controller and datapath.
//
//   Channel   Direction  Handshake             Beat contents
//   req_      in         req_valid/req_stall   mode, item_id, target_position
//   rsp_      out        rsp_valid/rsp_stall   status, entry_count
//
// One operation runs at a time, and every scan or shift step costs one memory read.
// A zero id or the unused mode is answered without a scan; an append or a miss scans
// every entry, a duplicate ends the scan at its slot, and a remove or move scans to the
// id, shifts the entries after its slot (remove) or up to the target slot (move), and
// then drops or places the id.
// Synchronous reset clears the count and the control state; the memory is not cleared,
// since only slots below the count are compared. A stalled result does not block a new
// request; the next result waits in the controller until the stalled beat is taken.
module ordered_unique_id_list #(
   parameter int LIST_DEPTH = oul_pkg::DEFAULT_LIST_DEPTH,
   parameter int ID_WIDTH   = oul_pkg::DEFAULT_ID_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  oul_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output oul_pkg::rsp_type rsp_data
);
   import oul_pkg::*;

   // Commands flow from the controller to the datapath, and the datapath
   // reports the scan result, list fullness and shift progress back.
   cmd_type  cmd;
   stat_type stat;

   // The controller sequences each operation: check the id, scan the list,
   // shift entries to close or open a gap, place the id and answer.
   oul_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the ids, the count and the result register.
   oul_dp #(
      .LIST_DEPTH (LIST_DEPTH),
      .ID_WIDTH   (ID_WIDTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
